// ===== rtl/ssp_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the split-step phase rotator.
package ssp_pkg;

	localparam int PHASE_TABLE_BITS = 12;
	localparam int QBITS            = PHASE_TABLE_BITS - 2;
	localparam int QSIZE            = 1 << QBITS;
	localparam int GRID_MAX         = 128;

	localparam int COORD_W = 29;  // signed Q.16 coordinate, origin plus index times step
	localparam int ABS_W   = 28;
	localparam int SUM_W   = 54;  // 2^32 + x^2/25 + y^2/16
	localparam int DIVQ_W  = 32;  // reciprocal bits, Q0.32
	localparam int REM_W   = 64;

	localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;  // floor(n/5) = (n*RECIP5) >> 34
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	typedef enum logic [7:0] {
		REG_MODE     = 8'd0,
		REG_GRID     = 8'd1,
		REG_KSCALE   = 8'd2,
		REG_PSCALE   = 8'd3,
		REG_STEP     = 8'd4,
		REG_ORIGIN   = 8'd5
	} cfg_reg_t;

	typedef struct packed {
		logic               mode;
		logic [7:0]         grid;
		logic [31:0]        kscale;
		logic [31:0]        pscale;
		logic [19:0]        step;
		logic signed [20:0] origin;
	} cfg_t;

	// Sample, mode and kinetic phase data that rides along with each beat.
	typedef struct packed {
		logic               mode;
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic [31:0]        phase_k;
	} side_t;

	typedef logic [15:0] sine_tab_t [0:QSIZE];

	localparam logic [63:0] TAYLOR_DIV [13] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
		64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
	};

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		return p[125:62];
	endfunction

	// Taylor series of sin in Q2.62, rounded to Q1.15.
	function automatic sine_tab_t build_sine_table();
		sine_tab_t   tab;
		logic [63:0] lowmask;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] jj;
		logic [63:0] rnd;
		lowmask = (64'd1 << QBITS) - 64'd1;
		for (int j = 0; j <= QSIZE; j++) begin
			jj   = 64'(j);
			x    = (HALF_PI_Q62 >> QBITS) * jj + (((HALF_PI_Q62 & lowmask) * jj) >> QBITS);
			x2   = mul_q62(x, x);
			term = x;
			sum  = x;
			for (int k = 0; k < 13; k++) begin
				term = mul_q62(term, x2) / TAYLOR_DIV[k];
				if ((k % 2) == 0) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			rnd    = (sum + (64'd1 << 46)) >> 47;
			tab[j] = rnd[15:0];
		end
		return tab;
	endfunction

endpackage

// ===== rtl/ssp_coord.sv =====
// Front stages: coordinates and squared distance sum, plus the kinetic phase.
module ssp_coord
	import ssp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  cfg_t                 cfg,
	input  logic                 in_v,
	input  logic [6:0]           row,
	input  logic [6:0]           col,
	input  side_t                in_side,
	output logic                 out_v,
	output logic [SUM_W-1:0]     out_sum,
	output side_t                out_side
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1
	logic signed [COORD_W-1:0] cx_s1, cy_s1;
	logic [16:0]               k2_s1;
	side_t                     side_s1;
	// stage 2
	logic [ABS_W-1:0]          ax_s2, ay_s2;
	logic [25:0]               mx_s2;
	side_t                     side_s2;
	// stage 3
	logic [51:0]               m2_s3;
	logic [55:0]               ay2_s3;
	logic [29:0]               u_s3;
	logic [2:0]                t_s3;
	side_t                     side_s3;
	// stage 4
	logic [51:0]               m2_s4;
	logic [55:0]               ay2_s4;
	logic [29:0]               u_s4;
	logic [27:0]               v5_s4;
	logic [2:0]                t_s4;
	side_t                     side_s4;
	// stage 5
	logic [SUM_W-1:0]          sum_s5;
	side_t                     side_s5;

	logic [26:0]               px, py;
	logic signed [COORD_W-1:0] cx, cy;
	logic [7:0]                n_clamp;
	logic [6:0]                half;
	logic signed [8:0]         kx, ky;
	logic signed [17:0]        kx2, ky2;
	logic [16:0]               k2;

	always_comb begin
		px = 27'({20'b0, row} * {7'b0, cfg.step});
		py = 27'({20'b0, col} * {7'b0, cfg.step});
		cx = {{(COORD_W-21){cfg.origin[20]}}, cfg.origin} + $signed({2'b0, px});
		cy = {{(COORD_W-21){cfg.origin[20]}}, cfg.origin} + $signed({2'b0, py});
		n_clamp = (cfg.grid > 8'(GRID_MAX)) ? 8'(GRID_MAX) : cfg.grid;
		half = n_clamp[7:1];
		kx = (row < half) ? $signed({2'b0, row}) : $signed({2'b0, row} - {1'b0, n_clamp});
		ky = (col < half) ? $signed({2'b0, col}) : $signed({2'b0, col} - {1'b0, n_clamp});
		kx2 = kx * kx;
		ky2 = ky * ky;
		k2 = 17'(kx2) + 17'(ky2);
	end

	logic [ABS_W-1:0] ax, ay;
	logic [59:0]      pmx;
	logic [48:0]      pk;
	logic [27:0]      r5;
	logic [28:0]      mt;
	logic [61:0]      pv;
	logic [29:0]      w5;
	logic [5:0]       frac;
	logic             extra;

	always_comb begin
		ax    = cx_s1[COORD_W-1] ? ABS_W'(-cx_s1) : cx_s1[ABS_W-1:0];
		ay    = cy_s1[COORD_W-1] ? ABS_W'(-cy_s1) : cy_s1[ABS_W-1:0];
		pmx   = {32'b0, ax} * {28'b0, RECIP5};
		pk    = {17'b0, cfg.kscale} * {32'b0, k2_s1};
		r5    = ax_s2 - 28'({2'b0, mx_s2} * 28'd5);
		mt    = {3'b0, mx_s2} * {26'b0, r5[2:0]};
		pv    = {32'b0, u_s3} * {30'b0, RECIP5};
		w5    = u_s4 - 30'({2'b0, v5_s4} * 30'd5);
		frac  = 6'(w5[2:0]) * 6'd5 + 6'(t_s4) * 6'(t_s4);
		extra = (frac >= 6'd25);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1   <= cx;
			cy_s1   <= cy;
			k2_s1   <= k2;
			side_s1 <= in_side;

			ax_s2   <= ax;
			ay_s2   <= ay;
			mx_s2   <= pmx[59:34];
			side_s2 <= '{mode: side_s1.mode, re: side_s1.re, im: side_s1.im,
				phase_k: 32'd0 - pk[31:0]};

			m2_s3   <= {26'b0, mx_s2} * {26'b0, mx_s2};
			ay2_s3  <= {28'b0, ay_s2} * {28'b0, ay_s2};
			u_s3    <= {mt, 1'b0};
			t_s3    <= r5[2:0];
			side_s3 <= side_s2;

			m2_s4   <= m2_s3;
			ay2_s4  <= ay2_s3;
			u_s4    <= u_s3;
			t_s4    <= t_s3;
			v5_s4   <= pv[61:34];
			side_s4 <= side_s3;

			sum_s5  <= (SUM_W'(1) << 32) + SUM_W'(m2_s4) + SUM_W'(v5_s4) + SUM_W'(extra)
				+ SUM_W'(ay2_s4[55:4]);
			side_s5 <= side_s4;
		end
	end

	assign out_v    = v_s5;
	assign out_sum  = sum_s5;
	assign out_side = side_s5;

endmodule

// ===== rtl/ssp_divider.sv =====
// Pipelined restoring divider: floor((2^64-1)/S), one quotient bit per stage.
module ssp_divider
	import ssp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [SUM_W-1:0]  in_den,
	input  side_t             in_side,
	output logic              out_v,
	output logic [DIVQ_W-1:0] out_quo,
	output side_t             out_side
);

	localparam int TRIAL_W = REM_W + DIVQ_W - 10;  // covers divisor shifted by DIVQ_W-1

	logic              v_s    [DIVQ_W];
	logic [REM_W-1:0]  rem_s  [DIVQ_W];
	logic [SUM_W-1:0]  den_s  [DIVQ_W];
	logic [DIVQ_W-1:0] quo_s  [DIVQ_W];
	side_t             side_s [DIVQ_W];

	for (genvar k = 0; k < DIVQ_W; k++) begin : g_stage
		localparam int SH = DIVQ_W - 1 - k;
		logic              v_in;
		logic [REM_W-1:0]  rem_in;
		logic [SUM_W-1:0]  den_in;
		logic [DIVQ_W-1:0] quo_in;
		side_t             side_in;
		logic [TRIAL_W-1:0] trial;

		if (k == 0) begin : g_first
			assign v_in    = in_v;
			assign rem_in  = '1;
			assign den_in  = in_den;
			assign quo_in  = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign den_in  = den_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign side_in = side_s[k-1];
		end

		// Subtract the shifted divisor; the top bit flags a borrow.
		assign trial = {{(TRIAL_W-REM_W){1'b0}}, rem_in}
			- ({{(TRIAL_W-SUM_W){1'b0}}, den_in} << SH);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= trial[TRIAL_W-1] ? rem_in : trial[REM_W-1:0];
				den_s[k]  <= den_in;
				quo_s[k]  <= {quo_in[DIVQ_W-2:0], ~trial[TRIAL_W-1]};
				side_s[k] <= side_in;
			end
		end
	end

	assign out_v    = v_s[DIVQ_W-1];
	assign out_quo  = quo_s[DIVQ_W-1];
	assign out_side = side_s[DIVQ_W-1];

endmodule

// ===== rtl/ssp_rotate.sv =====
// Back stages: fourth power of the reciprocal, phase select, sine lookup and complex rotate.
module ssp_rotate
	import ssp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [31:0]       pscale,
	input  logic              in_v,
	input  logic [DIVQ_W-1:0] in_quo,
	input  side_t             in_side,
	output logic              out_v,
	output logic [31:0]       out_real,
	output logic [31:0]       out_imag,
	output logic              out_sat
);

	localparam sine_tab_t SINE_ROM = build_sine_table();

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [31:0]        r2_s1;
	side_t              side_s1;
	logic [31:0]        r4_s2;
	side_t              side_s2;
	logic [31:0]        phase_s3;
	logic signed [31:0] re_s3, im_s3;
	logic [15:0]        sa_s4, sb_s4;
	logic [1:0]         quad_s4;
	logic signed [31:0] re_s4, im_s4;
	logic signed [16:0] c_s5, s_s5;
	logic signed [31:0] re_s5, im_s5;
	logic signed [48:0] rc_s6, is_s6, rs_s6, ic_s6;
	logic [31:0]        yr_s7, yi_s7;
	logic               sat_s7;

	logic [63:0] p1, p2, p3;
	always_comb begin
		p1 = {32'b0, in_quo} * {32'b0, in_quo};
		p2 = {32'b0, r2_s1} * {32'b0, r2_s1};
		p3 = {32'b0, pscale} * {32'b0, r4_s2};
	end

	logic [PHASE_TABLE_BITS-1:0] idx;
	logic [QBITS-1:0]            roff;
	logic [QBITS:0]              addr_a, addr_b;
	always_comb begin
		idx    = phase_s3[31 -: PHASE_TABLE_BITS];
		roff   = idx[QBITS-1:0];
		addr_a = {1'b0, roff};
		addr_b = (QBITS+1)'(QSIZE) - {1'b0, roff};
	end

	function automatic logic signed [16:0] clip_pos(input logic [15:0] v);
		return (v > 16'd32767) ? 17'sd32767 : $signed({1'b0, v});
	endfunction

	function automatic logic signed [16:0] negate(input logic [15:0] v);
		return -$signed({1'b0, v});
	endfunction

	logic signed [16:0] c_sel, s_sel;
	always_comb begin
		unique case (quad_s4)
			2'd0: begin
				c_sel = clip_pos(sb_s4);
				s_sel = clip_pos(sa_s4);
			end
			2'd1: begin
				c_sel = negate(sa_s4);
				s_sel = clip_pos(sb_s4);
			end
			2'd2: begin
				c_sel = negate(sb_s4);
				s_sel = negate(sa_s4);
			end
			default: begin
				c_sel = clip_pos(sa_s4);
				s_sel = negate(sb_s4);
			end
		endcase
	end

	// Round to nearest, ties up, then clip to 32 bits.
	logic signed [49:0] sum_r, sum_i;
	logic signed [34:0] q_r, q_i;
	logic               sat_r, sat_i;
	always_comb begin
		sum_r = 50'(rc_s6) - 50'(is_s6) + 50'sd16384;
		sum_i = 50'(rs_s6) + 50'(ic_s6) + 50'sd16384;
		q_r   = sum_r[49:15];
		q_i   = sum_i[49:15];
		sat_r = (q_r > 35'sd2147483647) || (q_r < -35'sd2147483648);
		sat_i = (q_i > 35'sd2147483647) || (q_i < -35'sd2147483648);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s1    <= p1[63:32];
			side_s1  <= in_side;
			r4_s2    <= p2[63:32];
			side_s2  <= side_s1;
			phase_s3 <= side_s2.mode ? side_s2.phase_k : p3[63:32];
			re_s3    <= side_s2.re;
			im_s3    <= side_s2.im;
			sa_s4    <= SINE_ROM[addr_a];
			sb_s4    <= SINE_ROM[addr_b];
			quad_s4  <= idx[PHASE_TABLE_BITS-1 -: 2];
			re_s4    <= re_s3;
			im_s4    <= im_s3;
			c_s5     <= c_sel;
			s_s5     <= s_sel;
			re_s5    <= re_s4;
			im_s5    <= im_s4;
			rc_s6    <= re_s5 * c_s5;
			is_s6    <= im_s5 * s_s5;
			rs_s6    <= re_s5 * s_s5;
			ic_s6    <= im_s5 * c_s5;
			yr_s7    <= (q_r > 35'sd2147483647) ? 32'h7FFFFFFF :
				(q_r < -35'sd2147483648) ? 32'h80000000 : q_r[31:0];
			yi_s7    <= (q_i > 35'sd2147483647) ? 32'h7FFFFFFF :
				(q_i < -35'sd2147483648) ? 32'h80000000 : q_i[31:0];
			sat_s7   <= sat_r | sat_i;
		end
	end

	assign out_v    = v_s7;
	assign out_real = yr_s7;
	assign out_imag = yi_s7;
	assign out_sat  = sat_s7;

endmodule

// ===== rtl/split_step_phase_rotator_unit.sv =====
// Top level of the split-step phase rotator: config registers, stream ports, pipeline.
// Pipeline: an accepted input beat reaches its result beat on the master side through
//   5 coordinate stages, 32 divider stages and 7 rotate stages.
// Throughput: one beat per cycle; the 32-stage reciprocal divider, one quotient bit per
//   stage, sets the depth, and the whole pipe holds while a result waits for m_tready.
// Reset: arst_n clears the config registers to their defaults and all stage valid bits.
module split_step_phase_rotator_unit
	import ssp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_addr,
	input  logic [31:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // row_index[6:0], col_index[13:7], psi_real[45:14],
	                               // psi_imag[77:46], zero pad
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_real[31:0], out_imag[63:32]
	output logic        m_tuser    // saturated
);

	cfg_t cfg_q;

	// Config writes land directly in the config registers; the channel never back-pressures.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= 1'b0;
			cfg_q.grid   <= 8'd128;
			cfg_q.kscale <= 32'd0;
			cfg_q.pscale <= 32'd0;
			cfg_q.step   <= 20'd13107;
			cfg_q.origin <= -21'sd655360;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				REG_MODE:   cfg_q.mode   <= cfg_data[0];
				REG_GRID:   cfg_q.grid   <= cfg_data[7:0];
				REG_KSCALE: cfg_q.kscale <= cfg_data;
				REG_PSCALE: cfg_q.pscale <= cfg_data;
				REG_STEP:   cfg_q.step   <= cfg_data[19:0];
				REG_ORIGIN: cfg_q.origin <= $signed(cfg_data[20:0]);
				default: ;  // drop writes to unknown indexes
			endcase
		end
	end

	// Advance every stage unless the output beat is held by the sink.
	logic en;
	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;

	side_t in_side;
	always_comb begin
		in_side.mode    = cfg_q.mode;
		in_side.re      = $signed(s_tdata[45:14]);
		in_side.im      = $signed(s_tdata[77:46]);
		in_side.phase_k = 32'd0;
	end

	logic             co_v;
	logic [SUM_W-1:0] co_sum;
	side_t            co_side;

	ssp_coord u_coord (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg_q),
		.in_v     (s_tvalid),
		.row      (s_tdata[6:0]),
		.col      (s_tdata[13:7]),
		.in_side  (in_side),
		.out_v    (co_v),
		.out_sum  (co_sum),
		.out_side (co_side)
	);

	logic              dv_v;
	logic [DIVQ_W-1:0] dv_quo;
	side_t             dv_side;

	ssp_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (co_v),
		.in_den   (co_sum),
		.in_side  (co_side),
		.out_v    (dv_v),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	logic [31:0] yr, yi;

	ssp_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.pscale   (cfg_q.pscale),
		.in_v     (dv_v),
		.in_quo   (dv_quo),
		.in_side  (dv_side),
		.out_v    (m_tvalid),
		.out_real (yr),
		.out_imag (yi),
		.out_sat  (m_tuser)
	);

	assign m_tdata = {yi, yr};

endmodule

// ===== dv/tb_top.sv =====
// Self-checking stream testbench for the split-step phase rotator unit.
module tb_top;
	import ssp_pkg::*;

	localparam int DRAIN_CYCLES = 60;     // wait past the pipe depth once the queues are empty
	localparam int STALL_LIMIT  = 20000;  // cycles with no beat on any channel
	localparam int LONG_HOLD    = 400;    // receiver hold-off for the pressure phase
	localparam int PHASE_ITEMS  = 160;

	typedef struct {
		logic [6:0]         row;
		logic [6:0]         col;
		logic signed [31:0] re;
		logic signed [31:0] im;
	} sample_t;

	typedef struct {
		logic signed [31:0] yr;
		logic signed [31:0] yi;
		logic               sat;
	} rotated_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_addr = '0;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;

	split_step_phase_rotator_unit dut (.*);

	always #5 clk = ~clk;

	// Shadow copy of the config registers.
	logic               sh_mode;
	logic [7:0]         sh_grid;
	logic [31:0]        sh_kscale;
	logic [31:0]        sh_pscale;
	logic [19:0]        sh_step;
	logic signed [20:0] sh_origin;

	int unsigned quarter_sine [0:1024];

	sample_t  pending_samples [$];
	rotated_t expected_rot [$];
	int       err_count = 0;
	int       in_beats = 0;
	int       out_beats = 0;
	int       sat_beats = 0;
	int       hold_req = 0;
	int       hold_done = 0;

	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		return p[125:62];
	endfunction

	// Quarter wave of sin in Q2.62 by Taylor series, rounded to Q1.15.
	task automatic fill_quarter_sine();
		logic [63:0] hp;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] rnd;
		hp = 64'h6487ED5110B4611A;
		for (int j = 0; j <= 1024; j++) begin
			x    = (hp >> 10) * 64'(j) + (((hp & 64'd1023) * 64'(j)) >> 10);
			x2   = q62_mul(x, x);
			term = x;
			acc  = x;
			for (int n = 3; n <= 27; n += 2) begin
				term = q62_mul(term, x2) / 64'(n * (n - 1));
				if (((n - 3) / 2) % 2 == 0) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			rnd = (acc + (64'd1 << 46)) >> 47;
			quarter_sine[j] = rnd[31:0];
		end
	endtask

	function automatic longint unsigned coord_square(input logic [6:0] idx);
		longint c;
		c = longint'(sh_origin) + longint'(idx) * longint'(sh_step);
		if (c < 0) c = -c;
		return longint'(c) * longint'(c);
	endfunction

	function automatic longint freq_of(input logic [6:0] idx, input int n);
		return (int'(idx) < n / 2) ? longint'(idx) : longint'(idx) - longint'(n);
	endfunction

	function automatic longint clip15(input longint v);
		return v > 32767 ? 32767 : v;
	endfunction

	function automatic logic signed [31:0] round_sat(input longint v, inout logic sat);
		longint q;
		q = (v + 16384) >>> 15;
		if (q > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (q < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return q[31:0];
	endfunction

	function automatic rotated_t rotate_sample(input sample_t smp);
		rotated_t        res;
		logic [31:0]     phase;
		longint unsigned big_s;
		longint unsigned rr;
		longint unsigned r2;
		longint unsigned r4;
		longint unsigned k2;
		longint unsigned prod;
		longint          kx;
		longint          ky;
		longint          c;
		longint          s;
		int              n;
		logic [11:0]     idx;
		int              r;
		if (!sh_mode) begin
			big_s = (64'd1 << 32) + coord_square(smp.row) / 25 + (coord_square(smp.col) >> 4);
			rr    = 64'hFFFFFFFFFFFFFFFF / big_s;
			r2    = (rr * rr) >> 32;
			r4    = (r2 * r2) >> 32;
			prod  = longint'(sh_pscale) * r4;
			phase = prod[63:32];
		end else begin
			n     = sh_grid > 128 ? 128 : int'(sh_grid);
			kx    = freq_of(smp.row, n);
			ky    = freq_of(smp.col, n);
			k2    = kx * kx + ky * ky;
			prod  = longint'(sh_kscale) * k2;
			phase = 32'd0 - prod[31:0];
		end
		idx = phase[31:20];
		r   = int'(idx[9:0]);
		case (idx[11:10])
			2'd0: begin
				c = clip15(quarter_sine[1024 - r]);
				s = clip15(quarter_sine[r]);
			end
			2'd1: begin
				c = -longint'(quarter_sine[r]);
				s = clip15(quarter_sine[1024 - r]);
			end
			2'd2: begin
				c = -longint'(quarter_sine[1024 - r]);
				s = -longint'(quarter_sine[r]);
			end
			default: begin
				c = clip15(quarter_sine[r]);
				s = -longint'(quarter_sine[1024 - r]);
			end
		endcase
		res.sat = 1'b0;
		res.yr  = round_sat(longint'(smp.re) * c - longint'(smp.im) * s, res.sat);
		res.yi  = round_sat(longint'(smp.re) * s + longint'(smp.im) * c, res.sat);
		return res;
	endfunction

	function automatic logic signed [31:0] rand_psi();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $signed(32'($urandom_range(0, 131072))) - 32'sd65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [6:0] rand_index();
		case ($urandom_range(0, 7))
			0: return 7'd0;
			1: return 7'd127;
			default: return 7'($urandom);
		endcase
	endfunction

	task automatic queue_sample(input logic [6:0] row, input logic [6:0] col,
	                            input logic signed [31:0] re, input logic signed [31:0] im);
		sample_t smp;
		smp.row = row;
		smp.col = col;
		smp.re  = re;
		smp.im  = im;
		pending_samples.push_back(smp);
	endtask

	// Write one config register; the shadow copy follows on the accepting edge.
	task automatic write_reg(input cfg_reg_t addr, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= addr;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (addr)
			REG_MODE:   sh_mode   = data[0];
			REG_GRID:   sh_grid   = data[7:0];
			REG_KSCALE: sh_kscale = data;
			REG_PSCALE: sh_pscale = data;
			REG_STEP:   sh_step   = data[19:0];
			REG_ORIGIN: sh_origin = data[20:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_samples.size() != 0 || expected_rot.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Driver: hold a beat until it is taken, then maybe idle before the next one.
	int src_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_rot.push_back(rotate_sample(pending_samples.pop_front()));
				in_beats++;
				if ($urandom_range(0, 3) == 0)
					src_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
					                                      : $urandom_range(1, 3);
			end
			if (s_tvalid && !s_tready) begin
				// hold the offered beat
			end else if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {2'b00, pending_samples[0].im, pending_samples[0].re,
				             pending_samples[0].col, pending_samples[0].row};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: check each result beat against the oldest prediction, and stall at random.
	int sink_gap = 0;
	always @(posedge clk) begin
		rotated_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				out_beats++;
				if (expected_rot.size() == 0) begin
					$error("result beat with no prediction waiting");
					err_count++;
				end else begin
					want = expected_rot.pop_front();
					if (m_tuser) sat_beats++;
					if (m_tdata[31:0] !== want.yr) begin
						$error("out_real: expected %0d, got %0d", want.yr, $signed(m_tdata[31:0]));
						err_count++;
					end
					if (m_tdata[63:32] !== want.yi) begin
						$error("out_imag: expected %0d, got %0d", want.yi, $signed(m_tdata[63:32]));
						err_count++;
					end
					if (m_tuser !== want.sat) begin
						$error("saturated: expected %0b, got %0b", want.sat, m_tuser);
						err_count++;
					end
				end
			end
			if (hold_done != hold_req) begin
				// long hold-off so the pipe fills and back-pressures the input
				hold_done = hold_req;
				sink_gap  = LONG_HOLD;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				sink_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
				                                       : $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if no channel moves for too long.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		sh_mode   = 1'b0;
		sh_grid   = 8'd128;
		sh_kscale = 32'd0;
		sh_pscale = 32'd0;
		sh_step   = 20'd13107;
		sh_origin = -21'sd655360;
		fill_quarter_sine();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: ; // reset defaults: zero phase
				1: write_reg(REG_PSCALE, 32'hFFFFFFFF);
				2: begin
					write_reg(REG_PSCALE, $urandom);
					write_reg(REG_STEP, 32'd0);
					write_reg(REG_ORIGIN, 32'h00100000);  // most negative origin
				end
				3: begin
					write_reg(REG_STEP, 32'h000FFFFF);
					write_reg(REG_ORIGIN, 32'h000FFFFF);
				end
				4: begin
					write_reg(REG_MODE, 32'd1);
					write_reg(REG_KSCALE, $urandom);
				end
				5: write_reg(REG_GRID, 32'd0);
				6: begin
					write_reg(REG_GRID, 32'd1);
					write_reg(REG_KSCALE, 32'hFFFFFFFF);
				end
				7: begin
					write_reg(REG_GRID, 32'd200);  // above the grid limit
					write_reg(REG_KSCALE, $urandom);
				end
				8: write_reg(REG_GRID, 32'd2);
				default: begin
					write_reg(cfg_reg_t'(8'd9), $urandom);  // unknown index, dropped
					write_reg(REG_MODE, 32'($urandom_range(0, 1)));
					write_reg(REG_GRID, 32'($urandom_range(2, 128)));
					write_reg(REG_KSCALE, $urandom);
					write_reg(REG_PSCALE, $urandom);
					write_reg(REG_STEP, $urandom);
					write_reg(REG_ORIGIN, $urandom);
					hold_req++;
				end
			endcase
			if (ph == 0 || ph == 4) begin
				// extremes and edge values of the sample and of the indices
				queue_sample(7'd0, 7'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
				queue_sample(7'd127, 7'd127, 32'sh80000000, 32'sh80000000);
				queue_sample(7'd0, 7'd127, 32'sh7FFFFFFF, 32'sh80000000);
				queue_sample(7'd127, 7'd0, 32'sh80000000, 32'sh7FFFFFFF);
				queue_sample(7'd64, 7'd63, 32'sd0, 32'sd0);
				queue_sample(7'd50, 7'd50, 32'sd65536, -32'sd65536);
				queue_sample(7'd1, 7'd126, -32'sd1, 32'sd1);
				queue_sample(7'd100, 7'd10, 32'sh40000000, 32'shC0000000);
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_sample(rand_index(), rand_index(), rand_psi(), rand_psi());
			drain();
		end

		$display("covered %0d samples over potential and kinetic settings, %0d saturated",
		         in_beats, sat_beats);
		if (err_count == 0 && out_beats == in_beats) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ssp_pkg.sv
rtl/ssp_coord.sv
rtl/ssp_divider.sv
rtl/ssp_rotate.sv
rtl/split_step_phase_rotator_unit.sv
dv/tb_top.sv
